// ===== src/ocvs_pkg.sv =====
// shared types, curve table and register codes for the ocv state-of-charge estimator
package ocvs_pkg;

    localparam int CURVE_POINTS = 12;
    localparam int SEG_W        = 4;
    localparam int MV_W         = 16;
    localparam int PCT_W        = 7;
    localparam int OFS_W        = 8;   // widest segment spans 150 mv
    localparam int RECIP_W      = 16;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = OFS_W + RECIP_W;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // open-circuit curve points, highest voltage first
    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        16'd4200, 16'd4100, 16'd4000, 16'd3930, 16'd3860, 16'd3800,
        16'd3750, 16'd3710, 16'd3670, 16'd3600, 16'd3450, 16'd3300
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
    };

    // per segment: ceil(2^16 / (mv span / pct step)); the divisors are 10, 7, 6, 5, 4 and 30
    // and the offsets stay small enough that the scaled product floors exactly
    localparam logic [RECIP_W-1:0] SEG_RECIP [CURVE_POINTS] = '{
        16'd0,     16'd6554,  16'd6554,  16'd9363,  16'd9363,  16'd10923,
        16'd13108, 16'd16384, 16'd16384, 16'd9363,  16'd2185,  16'd2185
    };

    // register map, word index of paddr
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_NO_BATTERY_MV   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_DESYNC_MV   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_DESYNC_PCT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_DESYNC_MV  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_DESYNC_PCT = 3'd4;

    localparam logic [MV_W-1:0]  RST_NO_BATTERY_MV   = 16'd3000;
    localparam logic [MV_W-1:0]  RST_LOW_DESYNC_MV   = 16'd3900;
    localparam logic [PCT_W-1:0] RST_LOW_DESYNC_PCT  = 7'd10;
    localparam logic [MV_W-1:0]  RST_HIGH_DESYNC_MV  = 16'd3500;
    localparam logic [PCT_W-1:0] RST_HIGH_DESYNC_PCT = 7'd90;

    typedef struct packed {
        logic [MV_W-1:0]  no_battery_mv;
        logic [MV_W-1:0]  low_desync_mv;
        logic [PCT_W-1:0] low_desync_pct;
        logic [MV_W-1:0]  high_desync_mv;
        logic [PCT_W-1:0] high_desync_pct;
    } t_ocvs_cfg;

endpackage

// ===== src/ocvs_curve.sv =====
// piecewise linear voltage to state-of-charge lookup
module ocvs_curve (
    input  logic [ocvs_pkg::MV_W-1:0]  i_mv,
    output logic [ocvs_pkg::PCT_W-1:0] o_pct
);
    import ocvs_pkg::*;

    logic [SEG_W-1:0]   seg;
    logic [MV_W-1:0]    diff;
    logic [OFS_W-1:0]   ofs;
    logic [PROD_W-1:0]  prod;
    logic [PCT_W-1:0]   step;

    // lowest point index whose voltage is at or below the sample
    always_comb begin
        seg = '0;
        for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
            if (i_mv >= CURVE_MV[k]) begin
                seg = SEG_W'(k);
            end
        end
    end

    assign diff = i_mv - CURVE_MV[seg];
    assign ofs  = diff[OFS_W-1:0];
    assign prod = PROD_W'(ofs) * PROD_W'(SEG_RECIP[seg]);
    assign step = prod[RECIP_SHIFT +: PCT_W];

    always_comb begin
        priority if (i_mv >= CURVE_MV[0]) begin
            o_pct = PCT_FULL;
        end else if (i_mv < CURVE_MV[CURVE_POINTS-1]) begin
            o_pct = '0;
        end else begin
            o_pct = CURVE_PCT[seg] + step;
        end
    end

endmodule

// ===== src/ocvs_check.sv =====
// plausibility check of the reported charge against the voltage
module ocvs_check (
    input  ocvs_pkg::t_ocvs_cfg         i_cfg,
    input  logic [ocvs_pkg::MV_W-1:0]  i_mv,
    input  logic [ocvs_pkg::PCT_W-1:0] i_rep,
    input  logic [ocvs_pkg::PCT_W-1:0] i_curve,
    output logic                       o_plausible,
    output logic [ocvs_pkg::PCT_W-1:0] o_chosen
);
    import ocvs_pkg::*;

    logic [PCT_W-1:0] rep_clamped;
    logic             low_desync;
    logic             high_desync;

    assign rep_clamped = (i_rep > PCT_FULL) ? PCT_FULL : i_rep;
    assign low_desync  = (i_mv >= i_cfg.low_desync_mv) && (rep_clamped <= i_cfg.low_desync_pct);
    assign high_desync = (i_mv <= i_cfg.high_desync_mv)
                         && (rep_clamped >= i_cfg.high_desync_pct);

    assign o_plausible = (i_mv < i_cfg.no_battery_mv) || !(low_desync || high_desync);
    assign o_chosen    = o_plausible ? rep_clamped : i_curve;

endmodule

// ===== src/ocv_soc_estimate_with_check_top.sv =====
// top level of the ocv state-of-charge estimator with plausibility check
// usage
//   slave stream s_axis: one beat per sample, voltage in mv and the gauge's
//   reported charge in percent (values above 100 are clamped to 100)
//   master stream m_axis: one beat per sample, curve charge, plausible flag
//   and the chosen charge (reported if plausible, else the curve value)
//   apb port: five threshold registers at byte addresses 0, 4, 8, 12, 16;
//   writes land on the access cycle, pready is tied high, reads return the value
// timing
//   two register stages: input register, then result register; a beat moves
//   from the input register to the result register once that is free and is
//   offered on m_axis from there; one beat per cycle sustained while m_axis_tready
//   is high, set by the single-pass curve lookup and check between the two stages
//   (one 8 by 16 multiply for the segment reciprocal)
// reset
//   synchronous active-low; both stages empty, registers back to their
//   defaults (3000, 3900, 10, 3500, 90)
// stall
//   when m_axis_tready is low the result register holds; the input register
//   takes one more beat if empty, after which s_axis_tready drops until space frees
module ocv_soc_estimate_with_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] batt_mv, [22:16] reported_pct, [23] zero
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] curve_pct, [7] plausible, [14:8] chosen_pct, [15] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ocvs_pkg::*;

    t_ocvs_cfg r_cfg;

    logic             r_in_valid;
    logic [MV_W-1:0]  r_in_mv;
    logic [PCT_W-1:0] r_in_rep;

    logic             r_out_valid;
    logic [PCT_W-1:0] r_out_curve;
    logic             r_out_plausible;
    logic [PCT_W-1:0] r_out_chosen;

    logic             out_ready;
    logic             in_ready;
    logic [REG_IDX_W-1:0] reg_idx;
    logic             cfg_wr;

    logic [PCT_W-1:0] curve_pct;
    logic             plausible;
    logic [PCT_W-1:0] chosen_pct;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.no_battery_mv   <= RST_NO_BATTERY_MV;
            r_cfg.low_desync_mv   <= RST_LOW_DESYNC_MV;
            r_cfg.low_desync_pct  <= RST_LOW_DESYNC_PCT;
            r_cfg.high_desync_mv  <= RST_HIGH_DESYNC_MV;
            r_cfg.high_desync_pct <= RST_HIGH_DESYNC_PCT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NO_BATTERY_MV:   r_cfg.no_battery_mv   <= pwdata[MV_W-1:0];
                REG_LOW_DESYNC_MV:   r_cfg.low_desync_mv   <= pwdata[MV_W-1:0];
                REG_LOW_DESYNC_PCT:  r_cfg.low_desync_pct  <= pwdata[PCT_W-1:0];
                REG_HIGH_DESYNC_MV:  r_cfg.high_desync_mv  <= pwdata[MV_W-1:0];
                REG_HIGH_DESYNC_PCT: r_cfg.high_desync_pct <= pwdata[PCT_W-1:0];
                default: ;  // unmapped words ignore the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NO_BATTERY_MV:   prdata = 32'(r_cfg.no_battery_mv);
            REG_LOW_DESYNC_MV:   prdata = 32'(r_cfg.low_desync_mv);
            REG_LOW_DESYNC_PCT:  prdata = 32'(r_cfg.low_desync_pct);
            REG_HIGH_DESYNC_MV:  prdata = 32'(r_cfg.high_desync_mv);
            REG_HIGH_DESYNC_PCT: prdata = 32'(r_cfg.high_desync_pct);
            default:             prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    // each stage loads when it is empty or its contents move on this edge
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && in_ready) begin
            r_in_mv  <= s_axis_tdata[15:0];
            r_in_rep <= s_axis_tdata[22:16];
        end
    end

    // ---------------- single-pass work ----------------
    ocvs_curve u_curve (
        .i_mv  (r_in_mv),
        .o_pct (curve_pct)
    );

    ocvs_check u_check (
        .i_cfg       (r_cfg),
        .i_mv        (r_in_mv),
        .i_rep       (r_in_rep),
        .i_curve     (curve_pct),
        .o_plausible (plausible),
        .o_chosen    (chosen_pct)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && out_ready) begin
            r_out_curve     <= curve_pct;
            r_out_plausible <= plausible;
            r_out_chosen    <= chosen_pct;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_chosen, r_out_plausible, r_out_curve};

endmodule

// ===== verif/ocvs_soc_checker.sv =====
// checker for the ocv state-of-charge estimator: predicts each result beat and compares it
`timescale 1ns / 1ps

module ocvs_soc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] batt_mv, [22:16] reported_pct, [23] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [6:0] curve_pct, [7] plausible, [14:8] chosen_pct, [15] zero
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_outstanding
);
    import ocvs_pkg::*;

    localparam int OCV_POINTS = 12;
    localparam int unsigned OCV_MV [OCV_POINTS] = '{
        4200, 4100, 4000, 3930, 3860, 3800, 3750, 3710, 3670, 3600, 3450, 3300
    };
    localparam int unsigned OCV_PCT [OCV_POINTS] = '{
        100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0
    };

    t_ocvs_cfg   thresholds;
    logic [15:0] soc_expected_q [$];

    // returns the result beat as packed on m_axis_tdata
    function automatic logic [15:0] soc_estimate(input logic [15:0] mv,
                                                 input logic [6:0] rep_raw,
                                                 input t_ocvs_cfg th);
        int unsigned rep;
        int unsigned curve;
        int          k;
        bit          found;
        bit          ok;
        rep   = (rep_raw > 7'd100) ? 100 : rep_raw;
        curve = 0;
        found = 1'b0;
        if (mv >= OCV_MV[0]) begin
            curve = 100;
        end else begin
            for (k = 1; k < OCV_POINTS; k++) begin
                if (!found && mv >= OCV_MV[k]) begin
                    curve = OCV_PCT[k] + ((mv - OCV_MV[k]) * (OCV_PCT[k-1] - OCV_PCT[k]))
                            / (OCV_MV[k-1] - OCV_MV[k]);
                    found = 1'b1;
                end
            end
        end
        ok = 1'b1;
        if (mv >= th.no_battery_mv) begin
            if (mv >= th.low_desync_mv && rep <= th.low_desync_pct)
                ok = 1'b0;
            if (mv <= th.high_desync_mv && rep >= th.high_desync_pct)
                ok = 1'b0;
        end
        return {1'b0, ok ? rep[6:0] : curve[6:0], ok, curve[6:0]};
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [15:0] want;
        logic [31:0] rd_want;
        bit          rd_known;
        if (!i_rst_n) begin
            thresholds.no_battery_mv   <= RST_NO_BATTERY_MV;
            thresholds.low_desync_mv   <= RST_LOW_DESYNC_MV;
            thresholds.low_desync_pct  <= RST_LOW_DESYNC_PCT;
            thresholds.high_desync_mv  <= RST_HIGH_DESYNC_MV;
            thresholds.high_desync_pct <= RST_HIGH_DESYNC_PCT;
            soc_expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                soc_expected_q.push_back(soc_estimate(i_s_tdata[15:0], i_s_tdata[22:16],
                                                      thresholds));
            if (i_m_tvalid && i_m_tready) begin
                if (soc_expected_q.size() == 0) begin
                    $display("%0t unexpected result beat: expected none, got %h",
                             $time, i_m_tdata);
                    o_mismatches++;
                end else begin
                    want = soc_expected_q.pop_front();
                    if (i_m_tdata !== want) begin
                        $display("%0t result mismatch: expected %h got %h",
                                 $time, want, i_m_tdata);
                        o_mismatches++;
                    end
                end
            end
            if (i_psel && i_penable && i_pready && i_pwrite) begin
                case (i_paddr[4:2])
                    REG_NO_BATTERY_MV:   thresholds.no_battery_mv   <= i_pwdata[15:0];
                    REG_LOW_DESYNC_MV:   thresholds.low_desync_mv   <= i_pwdata[15:0];
                    REG_LOW_DESYNC_PCT:  thresholds.low_desync_pct  <= i_pwdata[6:0];
                    REG_HIGH_DESYNC_MV:  thresholds.high_desync_mv  <= i_pwdata[15:0];
                    REG_HIGH_DESYNC_PCT: thresholds.high_desync_pct <= i_pwdata[6:0];
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pready && !i_pwrite) begin
                rd_known = 1'b1;
                rd_want  = '0;
                case (i_paddr[4:2])
                    REG_NO_BATTERY_MV:   rd_want = 32'(thresholds.no_battery_mv);
                    REG_LOW_DESYNC_MV:   rd_want = 32'(thresholds.low_desync_mv);
                    REG_LOW_DESYNC_PCT:  rd_want = 32'(thresholds.low_desync_pct);
                    REG_HIGH_DESYNC_MV:  rd_want = 32'(thresholds.high_desync_mv);
                    REG_HIGH_DESYNC_PCT: rd_want = 32'(thresholds.high_desync_pct);
                    default:             rd_known = 1'b0;
                endcase
                if (rd_known && i_prdata !== rd_want) begin
                    $display("%0t register read mismatch at %0d: expected %0d got %0d",
                             $time, i_paddr, rd_want, i_prdata);
                    o_mismatches++;
                end
            end
        end
        o_outstanding = soc_expected_q.size();
    end

endmodule

// ===== verif/tb_ocv_soc_estimate_with_check_top.sv =====
// testbench top for the ocv state-of-charge estimator: stimulus, register phases and verdict
`timescale 1ns / 1ps

module tb_ocv_soc_estimate_with_check_top;
    import ocvs_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int NUM_PHASES       = 7;
    localparam int SAMPLES_PER_PHASE = 200;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 6;    // two register stages, with margin
    localparam int NUM_DIRECTED     = 25;

    // an index past the register map, writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

    // curve ends, every curve point and a neighbour of several, threshold edges,
    // reported charge above 100 and the no-battery region
    localparam logic [15:0] DIRECTED_MV [NUM_DIRECTED] = '{
        16'd4200, 16'd4199, 16'd65535, 16'd4100, 16'd4099, 16'd4000, 16'd3999,
        16'd3930, 16'd3929, 16'd3900, 16'd3860, 16'd3800, 16'd3750, 16'd3710,
        16'd3670, 16'd3600, 16'd3500, 16'd3451, 16'd3450, 16'd3300, 16'd3299,
        16'd3000, 16'd2999, 16'd1,     16'd0
    };
    localparam logic [6:0] DIRECTED_PCT [NUM_DIRECTED] = '{
        7'd100, 7'd0,  7'd127, 7'd90, 7'd101, 7'd80, 7'd11,
        7'd10,  7'd70, 7'd10,  7'd60, 7'd50,  7'd40, 7'd30,
        7'd20,  7'd89, 7'd90,  7'd5,  7'd0,   7'd127, 7'd100,
        7'd90,  7'd127, 7'd64, 7'd0
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [15:0] batt_mv, [22:16] reported_pct, [23] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [6:0] curve_pct, [7] plausible, [14:8] chosen_pct, [15] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int        mismatches;
    int        outstanding;
    int        src_idle_pct;     // chance in a hundred that the sender idles a cycle
    int        sink_stall_pct;   // chance in a hundred that the receiver stalls a cycle
    int        hold_requests;    // bumped to ask the receiver for one long hold-off
    t_ocvs_cfg cur_cfg;

    ocv_soc_estimate_with_check_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // the checker watches both streams and the register port on its own
    ocvs_soc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off counted here when asked
    initial begin : sink
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // watchdog for a hung stream or register port
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[ocv_soc_estimate_with_check_top] ERROR");
        $finish;
    end

    // entered and left at a falling edge; valid stays high straight into the next beat
    task automatic send_sample(input logic [15:0] mv, input logic [6:0] rep);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rep, mv};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // setup then access; psel then stays quiet before the task returns, so it is never dropped and raised together
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val,
                             input int width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ({$urandom()} << width) | val;   // junk above the field must be dropped
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic read_back_all();
        apb_read(REG_NO_BATTERY_MV);
        apb_read(REG_LOW_DESYNC_MV);
        apb_read(REG_LOW_DESYNC_PCT);
        apb_read(REG_HIGH_DESYNC_MV);
        apb_read(REG_HIGH_DESYNC_PCT);
    endtask

    task automatic write_thresholds(input t_ocvs_cfg c);
        apb_write(REG_NO_BATTERY_MV,   32'(c.no_battery_mv),   MV_W);
        apb_write(REG_LOW_DESYNC_MV,   32'(c.low_desync_mv),   MV_W);
        apb_write(REG_LOW_DESYNC_PCT,  32'(c.low_desync_pct),  PCT_W);
        apb_write(REG_HIGH_DESYNC_MV,  32'(c.high_desync_mv),  MV_W);
        apb_write(REG_HIGH_DESYNC_PCT, 32'(c.high_desync_pct), PCT_W);
    endtask

    // wait until every result has come back and the pipeline has gone quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // threshold sets: realistic, all zero, all ones, overlapping windows, anything
    function automatic t_ocvs_cfg thresholds_for_phase(input int p);
        t_ocvs_cfg c;
        case (p)
            2: c = '{16'd0, 16'd0, 7'd0, 16'd0, 7'd0};
            3: c = '{16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 7'h7F};
            // both desync windows overlap over the whole curve
            4: c = '{16'd0, 16'd3300, 7'd100, 16'd4200, 7'd0};
            5: begin
                c.no_battery_mv   = 16'($urandom());
                c.low_desync_mv   = 16'($urandom());
                c.low_desync_pct  = 7'($urandom());
                c.high_desync_mv  = 16'($urandom());
                c.high_desync_pct = 7'($urandom());
            end
            default: begin
                c.no_battery_mv   = 16'($urandom_range(3400, 2800));
                c.low_desync_mv   = 16'($urandom_range(4200, 3700));
                c.low_desync_pct  = 7'($urandom_range(30, 0));
                c.high_desync_mv  = 16'($urandom_range(3800, 3300));
                c.high_desync_pct = 7'($urandom_range(100, 70));
            end
        endcase
        return c;
    endfunction

    // mostly voltages on the curve, some hugging a threshold, some anywhere
    function automatic logic [22:0] pick_sample(input t_ocvs_cfg c);
        logic [15:0] mv;
        logic [6:0]  rep;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: mv = 16'($urandom_range(4350, 3150));
            6: begin
                case ($urandom_range(2))
                    0:       mv = c.no_battery_mv;
                    1:       mv = c.low_desync_mv;
                    default: mv = c.high_desync_mv;
                endcase
                mv = mv + 16'($urandom_range(6)) - 16'd3;
            end
            7:       mv = 16'($urandom());
            8:       mv = 16'($urandom_range(4210, 2990));
            default: mv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        if ($urandom_range(3) == 0) begin
            rep = $urandom_range(1) ? c.low_desync_pct : c.high_desync_pct;
            rep = rep + 7'($urandom_range(2)) - 7'd1;
        end else begin
            rep = 7'($urandom_range(127));
        end
        return {rep, mv};
    endfunction

    initial begin : stimulus
        logic [22:0] smp;
        int          p;
        int          n;
        // every input known from time zero
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests  = 0;
        cur_cfg        = '{RST_NO_BATTERY_MV, RST_LOW_DESYNC_MV, RST_LOW_DESYNC_PCT,
                           RST_HIGH_DESYNC_MV, RST_HIGH_DESYNC_PCT};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values first, then the hand-picked corners at full rate
        read_back_all();
        for (n = 0; n < NUM_DIRECTED; n++)
            send_sample(DIRECTED_MV[n], DIRECTED_PCT[n]);

        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p > 0) begin
                cur_cfg = thresholds_for_phase(p);
                write_thresholds(cur_cfg);
                if (p == 1)
                    apb_write(REG_SPARE, 32'($urandom()), 0);
                read_back_all();
            end
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            // receiver holds off while the sender keeps pushing, so the input backs up
            if (p == 0)
                hold_requests++;
            for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
                smp = pick_sample(cur_cfg);
                send_sample(smp[15:0], smp[22:16]);
            end
        end

        drain();
        if (mismatches == 0)
            $display("[ocv_soc_estimate_with_check_top] OK");
        else
            $display("[ocv_soc_estimate_with_check_top] ERROR");
        $finish;
    end

endmodule
